@@ rtl/core/ifs_pkg.sv @@
// Shared constants and control types of the chaos-game step block.
package ifs_pkg;

  localparam int MAX_MAPS  = 20;
  localparam int FRAC_BITS = 16;
  localparam int SLOTS     = 6;
  localparam int MAP_W     = $clog2(MAX_MAPS);
  localparam int ADDR_W    = $clog2(MAX_MAPS * SLOTS);
  localparam int SUM_W     = $clog2(MAX_MAPS * 127 + 1);
  localparam int ACC_W     = 65;
  localparam int Q_W       = ACC_W - FRAC_BITS + 1;

  localparam logic [1:0] OP_LOAD_COEF = 2'd0;
  localparam logic [1:0] OP_LOAD_WGT  = 2'd1;
  localparam logic [1:0] OP_SET_POINT = 2'd2;
  localparam logic [1:0] OP_STEP      = 2'd3;

  localparam logic [7:0] REG_ENTRY_COUNT = 8'd0;
  localparam logic [7:0] REG_ZOOM        = 8'd1;
  localparam logic [7:0] REG_WIDTH       = 8'd2;
  localparam logic [7:0] REG_HEIGHT      = 8'd3;

  typedef enum logic [1:0] {
    MS_X  = 2'd0,
    MS_Y  = 2'd1,
    MS_ZX = 2'd2,
    MS_ZY = 2'd3
  } mul_src_t;

  typedef struct packed {
    logic              accept;
    logic              is_step;
    logic              sel_en;
    logic              sel_first;
    logic [MAP_W-1:0]  sel_idx;
    logic              rd_en;
    logic [2:0]        slot;
    logic              mul_en;
    mul_src_t          mul_src;
    logic              acc_en;
    logic              pix_en;
    logic              pix_y;
    logic              out_ld;
  } cmd_t;

  typedef struct packed {
    logic sel_done;
    logic out_free;
  } sts_t;

endpackage

@@ rtl/core/ifs_chaos_game_point_step.sv @@
// Chaos-game IFS step: one beat in, one result beat out. Each beat carries an opcode in
// in_tuser: load a coefficient, load a weight, set the point, or step. Loads and set
// point go from the accept state straight to the output state, which loads the result
// register when it is free. A step scans the weight table one entry per cycle until the
// running sum reaches draw+1 (bounded by entry_count), then runs the six coefficient
// slots through one shared 32x32 multiplier and a 65-bit accumulator, each slot passing
// a read, a multiply and an accumulate state, then projects x and y to a pixel through a
// multiply and an add state for each. Affine sums round half up and saturate to signed
// Q16.16 (overflow flags it). Pixel = floor(v*zoom + size/2 + 1/2). The coefficient
// store reads as zero until written (per-word valid bits, cleared at reset), so no
// clearing pass is needed. The result register lets a finished result wait for
// out_tready. Configuration is taken at any time through cfg_valid with cfg_ready tied
// high; write it only while idle.
module ifs_chaos_game_point_step (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // tdata: entry[4:0] slot[7:5] coef_value[39:8] weight[46:40] start_x[78:47]
  //        start_y[110:79] draw[117:111], zero fill
  input  logic [119:0] in_tdata,
  // tuser: opcode[1:0]
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // tdata: point_x_out[31:0] point_y_out[63:32] pixel_col[73:64] pixel_row[83:74]
  //        on_screen[84] chosen_map[89:85] overflow[90], zero fill
  output logic [95:0]  out_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [7:0]   cfg_index,
  input  logic [10:0]  cfg_data
);
  import ifs_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  ifs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .opcode   (in_tuser),
    .sts      (sts),
    .cmd      (cmd),
    .in_ready (in_tready)
  );

  ifs_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .opcode     (in_tuser),
    .entry      (in_tdata[4:0]),
    .slot       (in_tdata[7:5]),
    .coef_value (in_tdata[39:8]),
    .weight     (in_tdata[46:40]),
    .start_x    (in_tdata[78:47]),
    .start_y    (in_tdata[110:79]),
    .draw       (in_tdata[117:111]),
    .cfg_we     (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_data   (out_tdata)
  );

  // off-screen results carry a zero pixel
  a_offscreen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[84] |-> out_tdata[83:64] == 20'd0)
    else $error("pixel nonzero while off screen");

  // chosen map lies inside the table
  a_map_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> 32'(out_tdata[89:85]) < 32'(MAX_MAPS))
    else $error("chosen map out of range");

  // overflow implies a saturated coordinate
  a_ovf_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[90] |->
      out_tdata[31:0] == 32'h7FFFFFFF || out_tdata[31:0] == 32'h80000000 ||
      out_tdata[63:32] == 32'h7FFFFFFF || out_tdata[63:32] == 32'h80000000)
    else $error("overflow without saturation");

  // no new item is taken while a result is being built
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second item accepted back to back");

endmodule

@@ rtl/core/ifs_ctrl.sv @@
// Sequencer: selection scan, coefficient loop and pixel projection for a step, and the result load for every beat.
module ifs_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [1:0]        opcode,
  input  ifs_pkg::sts_t     sts,
  output ifs_pkg::cmd_t     cmd,
  output logic              in_ready
);
  import ifs_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE = 8'b00000001,
    S_SEL  = 8'b00000010,
    S_RD   = 8'b00000100,
    S_MUL  = 8'b00001000,
    S_ACC  = 8'b00010000,
    S_PXM  = 8'b00100000,
    S_PXA  = 8'b01000000,
    S_OUT  = 8'b10000000
  } state_t;

  state_t           state_r, state_nxt;
  logic [MAP_W-1:0] idx_r, idx_nxt;
  logic [2:0]       k_r, k_nxt;
  logic             py_r, py_nxt;
  logic             step_r, step_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt   = state_r;
    idx_nxt     = idx_r;
    k_nxt       = k_r;
    py_nxt      = py_r;
    step_nxt    = step_r;
    cmd         = '0;
    cmd.sel_idx = idx_r;
    cmd.slot    = k_r;
    cmd.pix_y   = py_r;
    cmd.is_step = step_r;
    cmd.mul_src = MS_X;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          step_nxt   = (opcode == OP_STEP);
          idx_nxt    = '0;
          state_nxt  = (opcode == OP_STEP) ? S_SEL : S_OUT;
        end
      end
      S_SEL: begin
        cmd.sel_en    = 1'b1;
        cmd.sel_first = (idx_r == '0);
        if (sts.sel_done) begin
          k_nxt     = 3'd0;
          state_nxt = S_RD;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_src = (k_r == 3'd0 || k_r == 3'd3) ? MS_X : MS_Y;
        state_nxt   = S_ACC;
      end
      S_ACC: begin
        cmd.acc_en = 1'b1;
        if (k_r == 3'(SLOTS - 1)) begin
          py_nxt    = 1'b0;
          state_nxt = S_PXM;
        end else begin
          k_nxt     = k_r + 3'd1;
          state_nxt = S_RD;
        end
      end
      S_PXM: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_src = py_r ? MS_ZY : MS_ZX;
        state_nxt   = S_PXA;
      end
      S_PXA: begin
        cmd.pix_en = 1'b1;
        if (py_r) begin
          state_nxt = S_OUT;
        end else begin
          py_nxt    = 1'b1;
          state_nxt = S_PXM;
        end
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.out_ld = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
      k_r     <= '0;
      py_r    <= 1'b0;
      step_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      k_r     <= k_nxt;
      py_r    <= py_nxt;
      step_r  <= step_nxt;
    end
  end

endmodule

@@ rtl/core/ifs_dp.sv @@
// Datapath: tables, point, shared multiplier, accumulator and result register.
module ifs_dp (
  input  logic          clk,
  input  logic          rst_n,
  input  ifs_pkg::cmd_t cmd,
  output ifs_pkg::sts_t sts,
  input  logic [1:0]    opcode,
  input  logic [4:0]    entry,
  input  logic [2:0]    slot,
  input  logic [31:0]   coef_value,
  input  logic [6:0]    weight,
  input  logic [31:0]   start_x,
  input  logic [31:0]   start_y,
  input  logic [6:0]    draw,
  input  logic          cfg_we,
  input  logic [7:0]    cfg_index,
  input  logic [10:0]   cfg_data,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [95:0]   out_data
);
  import ifs_pkg::*;

  localparam int NCOEF = MAX_MAPS * SLOTS;

  // configuration
  logic [4:0]  ecount_r;
  logic [6:0]  zoom_r;
  logic [10:0] width_r, height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ecount_r <= 5'd4;
      zoom_r   <= 7'd20;
      width_r  <= 11'd320;
      height_r <= 11'd256;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ENTRY_COUNT: ecount_r <= cfg_data[4:0];
        REG_ZOOM:        zoom_r   <= cfg_data[6:0];
        REG_WIDTH:       width_r  <= cfg_data;
        REG_HEIGHT:      height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // coefficient memory, valid bit per word
  logic [31:0]       mem [NCOEF];
  logic [NCOEF-1:0]  vld_r;
  logic [31:0]       rd_r;
  logic              rd_vld_r;
  logic              wr_coef;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic [MAP_W-1:0]  pick_r;

  assign wr_coef = cmd.accept && opcode == OP_LOAD_COEF && 32'(entry) < 32'(MAX_MAPS)
                   && 32'(slot) < 32'(SLOTS);
  assign wr_addr = ADDR_W'(entry) * ADDR_W'(SLOTS) + ADDR_W'(slot);
  assign rd_addr = ADDR_W'(pick_r) * ADDR_W'(SLOTS) + ADDR_W'(cmd.slot);

  always_ff @(posedge clk) begin
    if (wr_coef) mem[wr_addr] <= coef_value;
    if (cmd.rd_en) rd_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_coef) vld_r[wr_addr] <= 1'b1;
      if (cmd.rd_en) rd_vld_r <= vld_r[rd_addr];
    end
  end

  logic [31:0] coef;
  assign coef = rd_vld_r ? rd_r : 32'd0;

  // weights and selection scan
  logic [6:0]       wgt_r [MAX_MAPS];
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [7:0]       need_r;
  logic [MAP_W-1:0] last_idx;

  always_comb begin
    if (ecount_r == 5'd0)                 last_idx = '0;
    else if (32'(ecount_r) > 32'(MAX_MAPS)) last_idx = MAP_W'(MAX_MAPS - 1);
    else                                  last_idx = MAP_W'(ecount_r - 5'd1);
  end

  assign sum_nxt = (cmd.sel_first ? '0 : sum_r) + SUM_W'(wgt_r[cmd.sel_idx]);
  assign sts.sel_done = (sum_nxt >= SUM_W'(need_r)) || (cmd.sel_idx == last_idx);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_MAPS; i++) wgt_r[i] <= '0;
    end else if (cmd.accept && opcode == OP_LOAD_WGT && 32'(entry) < 32'(MAX_MAPS)) begin
      wgt_r[entry[MAP_W-1:0]] <= weight;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) need_r <= {1'b0, draw} + 8'd1;
    if (cmd.sel_en) begin
      sum_r <= sum_nxt;
      if (sts.sel_done) pick_r <= cmd.sel_idx;
    end
  end

  // point, shared multiplier, accumulator
  logic signed [31:0]    px_r, py_r, nx_r, ny_r;
  logic signed [31:0]    op_a, op_b;
  logic signed [63:0]    prod_r;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [Q_W-1:0] q;
  logic [31:0]           q_sat;
  logic                  q_ovf, ovf_r;

  always_comb begin
    unique case (cmd.mul_src)
      MS_X:  begin op_a = coef; op_b = px_r; end
      MS_Y:  begin op_a = coef; op_b = py_r; end
      MS_ZX: begin op_a = nx_r; op_b = {25'd0, zoom_r}; end
      MS_ZY: begin op_a = ny_r; op_b = {25'd0, zoom_r}; end
      default: begin op_a = coef; op_b = px_r; end
    endcase
  end

  assign q = Q_W'(acc_r >>> FRAC_BITS) + Q_W'($signed(coef));

  always_comb begin
    q_ovf = 1'b1;
    if (q > Q_W'(64'sh7FFFFFFF))       q_sat = 32'h7FFFFFFF;
    else if (q < -Q_W'(64'sh80000000)) q_sat = 32'h80000000;
    else begin
      q_sat = q[31:0];
      q_ovf = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) prod_r <= op_a * op_b;
    if (cmd.accept) ovf_r <= 1'b0;
    if (cmd.acc_en) begin
      unique case (cmd.slot)
        3'd0, 3'd3: acc_r <= ACC_W'(prod_r);
        3'd1, 3'd4: acc_r <= acc_r + ACC_W'(prod_r) + ACC_W'(1 << (FRAC_BITS - 1));
        3'd2: begin
          nx_r  <= q_sat;
          ovf_r <= ovf_r | q_ovf;
        end
        default: begin
          ny_r  <= q_sat;
          ovf_r <= ovf_r | q_ovf;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      px_r <= '0;
      py_r <= '0;
    end else if (cmd.accept && opcode == OP_SET_POINT) begin
      px_r <= start_x;
      py_r <= start_y;
    end else if (cmd.out_ld && cmd.is_step) begin
      px_r <= nx_r;
      py_r <= ny_r;
    end
  end

  // pixel projection
  logic [10:0]        size;
  logic signed [63:0] t;
  logic signed [47:0] pix;
  logic               in_rng, visx_r;
  logic [9:0]         col_r, row_r;
  logic               vis_r;

  assign size   = cmd.pix_y ? height_r : width_r;
  assign t      = prod_r + (64'(size >> 1) << FRAC_BITS) + 64'(1 << (FRAC_BITS - 1));
  assign pix    = 48'(t >>> FRAC_BITS);
  assign in_rng = !pix[47] && pix < 48'(size);

  always_ff @(posedge clk) begin
    if (cmd.pix_en) begin
      if (cmd.pix_y) begin
        row_r <= pix[9:0];
        vis_r <= visx_r && in_rng;
      end else begin
        col_r  <= pix[9:0];
        visx_r <= in_rng;
      end
    end
  end

  // result register
  logic        ov_r;
  logic [95:0] od_r;

  assign sts.out_free = !ov_r || out_ready;
  assign out_valid    = ov_r;
  assign out_data     = od_r;

  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else if (cmd.out_ld) ov_r <= 1'b1;
    else if (out_ready) ov_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      if (cmd.is_step) begin
        od_r <= {5'd0, ovf_r, 5'(pick_r), vis_r, vis_r ? row_r : 10'd0,
                 vis_r ? col_r : 10'd0, ny_r, nx_r};
      end else begin
        od_r <= {32'd0, py_r, px_r};
      end
    end
  end

endmodule

@@ sim/tb_ifs_chaos_game_point_step.sv @@
// Self-checking testbench for the chaos-game IFS point step block.
`timescale 1ns / 100ps

module tb_ifs_chaos_game_point_step;
  import ifs_pkg::*;

  localparam logic [7:0] REG_UNUSED = 8'd9;   // index with no register behind it
  localparam int         IDLE_LIMIT = 20000;  // cycles with no beat at all before giving up
  localparam int         LONG_HOLD  = 400;    // receiver back-pressure stretch
  localparam int         RAND_ITEMS = 700;

  typedef struct {
    logic [1:0]  op;
    logic [4:0]  entry;
    logic [2:0]  slot;
    logic [31:0] coef;
    logic [6:0]  weight;
    logic [31:0] sx;
    logic [31:0] sy;
    logic [6:0]  draw;
  } beat_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [119:0] in_tdata;
  logic [1:0]   in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [95:0]  out_tdata;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [7:0]   cfg_index;
  logic [10:0]  cfg_data;

  ifs_chaos_game_point_step u_top (.*);

  // Shadow copy of the block state and its registers
  logic signed [31:0] coef_mem [0:MAX_MAPS*SLOTS-1];
  logic        [6:0]  wgt_mem  [0:MAX_MAPS-1];
  logic signed [31:0] cur_x, cur_y;
  logic [4:0]         sh_count;
  logic [6:0]         sh_zoom;
  logic [10:0]        sh_width, sh_height;

  logic [95:0] pending_res[$];  // results still owed by the block, oldest first
  int          err_cnt;
  int          idle_cycles;
  bit          stall_req;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [95:0] pack_res(logic [31:0] x, logic [31:0] y, logic [9:0] col,
                                          logic [9:0] row, logic vis, logic [4:0] ch,
                                          logic ovf);
    return {5'b0, ovf, ch, vis, row, col, y, x};
  endfunction

  // Round half up of (p1 + p2) / 2^F + k, saturated to signed 32 bits
  function automatic logic signed [31:0] affine_sat(longint p1, longint p2,
                                                    logic signed [31:0] k, ref logic ovf);
    logic signed [69:0] s;
    s = p1;
    s = s + p2 + longint'(k) * longint'(65536) + 70'sd32768;
    s = s >>> FRAC_BITS;
    if (s > 70'sd2147483647) begin
      ovf = 1'b1;
      return 32'sh7fffffff;
    end
    if (s < -70'sd2147483648) begin
      ovf = 1'b1;
      return 32'sh80000000;
    end
    return s[31:0];
  endfunction

  function automatic longint pixel_of(logic signed [31:0] v, logic [10:0] size);
    longint t;
    t = longint'(v) * longint'(sh_zoom) + longint'(size / 2) * 65536 + 32768;
    return t >>> FRAC_BITS;
  endfunction

  // Advances the shadow state by one beat and returns the result it should produce
  function automatic logic [95:0] step_point(beat_t b);
    int                 act, pick, sum, idx;
    bit                 found;
    logic               ovf;
    logic signed [31:0] nx, ny;
    longint             px, py;
    logic [9:0]         col, row;
    logic               vis;
    ovf = 1'b0;
    case (b.op)
      OP_LOAD_COEF: begin
        if (b.entry < MAX_MAPS && b.slot < SLOTS) coef_mem[b.entry*SLOTS + b.slot] = b.coef;
        return pack_res(cur_x, cur_y, 0, 0, 0, 0, 0);
      end
      OP_LOAD_WGT: begin
        if (b.entry < MAX_MAPS) wgt_mem[b.entry] = b.weight;
        return pack_res(cur_x, cur_y, 0, 0, 0, 0, 0);
      end
      OP_SET_POINT: begin
        cur_x = b.sx;
        cur_y = b.sy;
        return pack_res(cur_x, cur_y, 0, 0, 0, 0, 0);
      end
      default: begin
        act = (sh_count == 0) ? 1 : (sh_count > MAX_MAPS) ? MAX_MAPS : sh_count;
        pick = act - 1;
        sum = 0;
        found = 0;
        for (int i = 0; i < act; i++) begin
          sum += wgt_mem[i];
          if (!found && sum >= int'(b.draw) + 1) begin
            pick = i;
            found = 1;
          end
        end
        idx = pick * SLOTS;
        // slots: a, b, e, c, d, f
        nx = affine_sat(longint'(coef_mem[idx]) * longint'(cur_x),
                        longint'(coef_mem[idx+1]) * longint'(cur_y), coef_mem[idx+2], ovf);
        ny = affine_sat(longint'(coef_mem[idx+3]) * longint'(cur_x),
                        longint'(coef_mem[idx+4]) * longint'(cur_y), coef_mem[idx+5], ovf);
        cur_x = nx;
        cur_y = ny;
        px = pixel_of(nx, sh_width);
        py = pixel_of(ny, sh_height);
        vis = (px >= 0 && px < longint'(sh_width) && py >= 0 && py < longint'(sh_height));
        col = vis ? px[9:0] : 10'd0;
        row = vis ? py[9:0] : 10'd0;
        return pack_res(cur_x, cur_y, col, row, vis, pick[4:0], ovf);
      end
    endcase
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic beat_t mk(logic [1:0] op, logic [4:0] entry, logic [2:0] slot,
                               logic [31:0] coef, logic [6:0] weight, logic [31:0] sx,
                               logic [31:0] sy, logic [6:0] draw);
    beat_t b;
    b.op = op; b.entry = entry; b.slot = slot; b.coef = coef; b.weight = weight;
    b.sx = sx; b.sy = sy; b.draw = draw;
    return b;
  endfunction

  // Random beat: mostly steps, small coefficients so the orbit stays in range,
  // with full-range values and out-of-range addresses mixed in as noise
  function automatic beat_t rand_beat();
    beat_t b;
    int    r;
    b = mk(2'($urandom), 5'($urandom), 3'($urandom), $urandom, 7'($urandom), $urandom,
           $urandom, 7'($urandom));
    r = $urandom_range(0, 99);
    b.op = (r < 60) ? OP_STEP : (r < 80) ? OP_LOAD_COEF : (r < 90) ? OP_LOAD_WGT : OP_SET_POINT;
    if ($urandom_range(0, 9) != 0) b.entry = 5'($urandom_range(0, MAX_MAPS - 1));
    if ($urandom_range(0, 9) != 0) b.slot = 3'($urandom_range(0, SLOTS - 1));
    if ($urandom_range(0, 4) != 0) b.coef = $urandom_range(0, 131072) - 65536;
    if ($urandom_range(0, 6) != 0) b.weight = 7'($urandom_range(0, 40));
    if ($urandom_range(0, 6) != 0) begin
      b.sx = $urandom_range(0, 524288) - 262144;
      b.sy = $urandom_range(0, 524288) - 262144;
    end
    if ($urandom_range(0, 9) != 0) b.draw = 7'($urandom_range(0, 99));
    return b;
  endfunction

  // Offer one beat, predict at acceptance, then maybe drop valid for a gap.
  // With no gap valid stays high and the next call just swaps the data.
  task automatic send_beat(beat_t b, bit typed, logic [95:0] typed_res);
    logic [95:0] pred;
    int          gap;
    in_tvalid <= 1'b1;
    in_tuser  <= b.op;
    in_tdata  <= {2'b0, b.draw, b.sy, b.sx, b.weight, b.coef, b.slot, b.entry};
    do @(posedge clk); while (!in_tready);
    pred = step_point(b);
    pending_res.push_back(typed ? typed_res : pred);
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop offering and wait until every owed result has come back
  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // Register write, only issued while the block is idle
  task automatic write_reg(logic [7:0] idx, logic [10:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_ENTRY_COUNT: sh_count  = val[4:0];
      REG_ZOOM:        sh_zoom   = val[6:0];
      REG_WIDTH:       sh_width  = val;
      REG_HEIGHT:      sh_height = val;
      default: ;
    endcase
  endtask

  task automatic set_regs(logic [10:0] cnt, logic [10:0] zm, logic [10:0] w, logic [10:0] h);
    write_reg(REG_ENTRY_COUNT, cnt);
    write_reg(REG_ZOOM, zm);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
  endtask

  task automatic chk(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      err_cnt++;
      $display("%0t: %s mismatch, expected %h, got %h", $realtime, name, want, got);
    end
  endtask

  // Result checker: one owed result per accepted output beat
  always @(posedge clk) begin
    logic [95:0] want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_res.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected result beat, expected none, got %h", $realtime, out_tdata);
      end else begin
        want = pending_res.pop_front();
        chk("point_x_out", want[31:0], out_tdata[31:0]);
        chk("point_y_out", want[63:32], out_tdata[63:32]);
        chk("pixel_col", want[73:64], out_tdata[73:64]);
        chk("pixel_row", want[83:74], out_tdata[83:74]);
        chk("on_screen", want[84], out_tdata[84]);
        chk("chosen_map", want[89:85], out_tdata[89:85]);
        chk("overflow", want[90], out_tdata[90]);
      end
    end
  end

  // Receiver: random short/long holds, plus one long hold on request
  initial begin
    int hold;
    hold = 0;
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_req) begin
        stall_req = 1'b0;
        hold = LONG_HOLD;
      end
      if (hold > 0) begin
        hold--;
        out_tready <= 1'b0;
      end else if ($urandom_range(0, 99) < 30) begin
        hold = pick_gap();
        out_tready <= (hold == 0);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Watchdog: ends the run when nothing moves for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("tb_ifs_chaos_game_point_step failed");
      $finish;
    end
  end

  initial begin
    beat_t       dir_beats[$];
    bit          dir_typed[$];
    logic [95:0] dir_res[$];
    err_cnt     = 0;
    idle_cycles = 0;
    stall_req   = 1'b0;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = OP_LOAD_COEF;
    cfg_valid   = 1'b0;
    cfg_index   = REG_ENTRY_COUNT;
    cfg_data    = '0;
    for (int i = 0; i < MAX_MAPS*SLOTS; i++) coef_mem[i] = '0;
    for (int i = 0; i < MAX_MAPS; i++) wgt_mem[i] = '0;
    cur_x = '0; cur_y = '0;
    sh_count = 5'd4; sh_zoom = 7'd20; sh_width = 11'd320; sh_height = 11'd256;

    // Directed table. After reset all maps are zero and no weight reaches the draw,
    // so the first step falls back to the last active map and lands on screen centre.
    dir_beats.push_back(mk(OP_STEP, 0, 0, 0, 0, 0, 0, 0));
    dir_typed.push_back(1); dir_res.push_back(pack_res(0, 0, 160, 128, 1, 3, 0));
    dir_beats.push_back(mk(OP_SET_POINT, 0, 0, 0, 0, 32'h7fffffff, 32'h80000000, 0));
    dir_typed.push_back(1);
    dir_res.push_back(pack_res(32'h7fffffff, 32'h80000000, 0, 0, 0, 0, 0));
    dir_beats.push_back(mk(OP_LOAD_WGT, 0, 0, 0, 100, 0, 0, 0));
    dir_beats.push_back(mk(OP_LOAD_COEF, 0, 0, 32'h7fffffff, 0, 0, 0, 0));
    dir_beats.push_back(mk(OP_LOAD_COEF, 0, 1, 32'h7fffffff, 0, 0, 0, 0));
    dir_beats.push_back(mk(OP_LOAD_COEF, 0, 3, 32'h80000000, 0, 0, 0, 0));
    dir_beats.push_back(mk(OP_LOAD_COEF, 0, 4, 32'h80000000, 0, 0, 0, 0));
    dir_beats.push_back(mk(OP_STEP, 0, 0, 0, 0, 0, 0, 0));
    dir_beats.push_back(mk(OP_SET_POINT, 0, 0, 0, 0, 32'h80000000, 32'h80000000, 0));
    dir_beats.push_back(mk(OP_STEP, 0, 0, 0, 0, 0, 0, 99));    // both sums saturate
    // loads aimed outside the table are dropped
    dir_beats.push_back(mk(OP_LOAD_WGT, 31, 0, 0, 127, 0, 0, 0));
    dir_beats.push_back(mk(OP_LOAD_COEF, 20, 0, 32'h12345678, 0, 0, 0, 0));
    dir_beats.push_back(mk(OP_LOAD_COEF, 0, 7, 32'h12345678, 0, 0, 0, 0));
    dir_beats.push_back(mk(OP_LOAD_WGT, 0, 0, 0, 0, 0, 0, 0));
    dir_beats.push_back(mk(OP_LOAD_WGT, 1, 0, 0, 127, 0, 0, 0)); // weight above 100
    dir_beats.push_back(mk(OP_LOAD_COEF, 1, 2, 32'h7fffffff, 0, 0, 0, 0));
    dir_beats.push_back(mk(OP_LOAD_COEF, 1, 5, 32'h80000000, 0, 0, 0, 0));
    dir_beats.push_back(mk(OP_STEP, 0, 0, 0, 0, 0, 0, 50));
    dir_beats.push_back(mk(OP_STEP, 0, 0, 0, 0, 0, 0, 127));   // draw above 99
    dir_beats.push_back(mk(OP_LOAD_COEF, 3, 0, 32'h00010000, 0, 0, 0, 0));
    dir_beats.push_back(mk(OP_LOAD_WGT, 1, 0, 0, 0, 0, 0, 0));
    dir_beats.push_back(mk(OP_SET_POINT, 0, 0, 0, 0, 32'h00020000, 32'hfffe8000, 0));
    dir_beats.push_back(mk(OP_STEP, 0, 0, 0, 0, 0, 0, 0));     // fallback to map 3
    while (dir_typed.size() < dir_beats.size()) begin
      dir_typed.push_back(0);
      dir_res.push_back('0);
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_beats[i]) send_beat(dir_beats[i], dir_typed[i], dir_res[i]);

    // Random phases, each under its own register setting; extremes first
    for (int ph = 0; ph < 7; ph++) begin
      drain();
      case (ph)
        0: set_regs(0, 0, 0, 0);
        1: set_regs(31, 127, 2047, 2047);
        2: set_regs(20, 1, 1, 1);
        3: begin
          set_regs(1, 100, 1024, 1024);
          write_reg(REG_UNUSED, 11'h7ff);
        end
        default: set_regs(11'($urandom_range(1, 20)), 11'($urandom_range(1, 100)),
                          11'($urandom_range(1, 1024)), 11'($urandom_range(1, 1024)));
      endcase
      for (int n = 0; n < RAND_ITEMS / 7; n++) begin
        if (ph == 2 && n == 20) stall_req = 1'b1;  // block fills up while we keep sending
        if (ph == 4 && n == 50) drain();           // sender pause until all results are in
        send_beat(rand_beat(), 0, '0);
      end
    end

    drain();
    repeat (60) @(posedge clk);
    if (err_cnt == 0 && pending_res.size() == 0)
      $display("tb_ifs_chaos_game_point_step passed");
    else
      $display("tb_ifs_chaos_game_point_step failed");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/ifs_pkg.sv
rtl/core/ifs_ctrl.sv
rtl/core/ifs_dp.sv
rtl/core/ifs_chaos_game_point_step.sv
sim/tb_ifs_chaos_game_point_step.sv
